// ----- design/tla_pkg.sv -----
package tla_pkg;

	localparam int ROWS   = 256;
	localparam int COLS   = 256;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int SIZE_W = 9;
	localparam int CNT_W  = 4;
	localparam int MIN_SIZE = 3;

	localparam int BIRTH_COUNT = 3;
	localparam int SURVIVE_LOW = 2;

	localparam int OP_W      = 2;
	localparam int OP_LSB    = 0;
	localparam int ROW_LSB   = OP_LSB + OP_W;
	localparam int COL_LSB   = ROW_LSB + 8;
	localparam int ALIVE_LSB = COL_LSB + 8;
	localparam int IN_W      = 24;

	localparam int OUT_ALIVE_LSB = 0;
	localparam int OUT_CNT_LSB   = 1;
	localparam int OUT_W         = 8;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

	localparam logic [SIZE_W-1:0] ROWS_RESET = 9'd160;
	localparam logic [SIZE_W-1:0] COLS_RESET = 9'd240;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WCELL,
		S_LRD,
		S_LSH,
		S_ROW,
		S_SH0,
		S_OUT
	} state_t;

	typedef struct packed {
		logic cap;
		logic init_read;
		logic init_step;
		logic wr_cell;
		logic rd;
		logic shift;
		logic use_row0;
		logic wr_row;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last_row;
		logic next_last;
	} stat_t;

endpackage

// ----- design/tla_ctrl.sv -----
module tla_ctrl import tla_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] op,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  stat_t           stat,
	output cmd_t            cmd
);

	state_t     state_q, state_d;
	logic [1:0] loads_q, loads_d;
	logic       mode_q, mode_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loads_q     <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			loads_q <= loads_d;
			mode_q  <= mode_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		loads_d  = loads_q;
		mode_d   = mode_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					unique case (op)
						OP_WRITE: begin
							state_d = S_WCELL;
						end
						OP_STEP: begin
							cmd.init_step = 1'b1;
							loads_d       = 2'd2;
							mode_d        = 1'b1;
							state_d       = S_LRD;
						end
						OP_READ: begin
							cmd.init_read = 1'b1;
							loads_d       = 2'd2;
							mode_d        = 1'b0;
							state_d       = S_LRD;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WCELL: begin
				cmd.wr_cell = 1'b1;
				state_d     = S_IDLE;
			end
			S_LRD: begin
				cmd.rd  = 1'b1;
				state_d = S_LSH;
			end
			S_LSH: begin
				cmd.shift = 1'b1;
				if (loads_q == 2'd0) begin
					state_d = mode_q ? S_ROW : S_OUT;
				end else begin
					loads_d = loads_q - 2'd1;
					state_d = S_LRD;
				end
			end
			S_ROW: begin
				cmd.wr_row = 1'b1;
				if (stat.last_row) begin
					state_d = S_IDLE;
				end else if (stat.next_last) begin
					state_d = S_SH0;
				end else begin
					loads_d = 2'd0;
					state_d = S_LRD;
				end
			end
			S_SH0: begin
				cmd.shift    = 1'b1;
				cmd.use_row0 = 1'b1;
				state_d      = S_ROW;
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/tla_datapath.sv -----
module tla_datapath import tla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic [IN_W-1:0]      in_data,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic [OUT_W-1:0]     out_data
);

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(MIN_SIZE)) begin
			r = SIZE_W'(MIN_SIZE);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [SIZE_W-1:0] rows_q, cols_q;
	logic [SIZE_W-1:0] nr, nc;
	logic [ROW_W-1:0]  nr_m1;
	logic [COL_W-1:0]  nc_m1;

	logic [ROW_W-1:0] in_row;
	logic [COL_W-1:0] in_col;
	logic             in_alive;

	logic [ROW_W-1:0] row_q, ptr_q, cur_q;
	logic [COL_W-1:0] col_q;
	logic             alive_q, inside_q;

	logic [COLS-1:0] mem [ROWS];
	logic            vld_q [ROWS];
	logic [COLS-1:0] rdat_s1;
	logic            rvld_s1;
	logic [COLS-1:0] top_q, mid_q, bot_q, row0_q;
	logic [COLS-1:0] next_row;
	logic [CNT_W-1:0] cnt [COLS];
	logic            top_last, mid_last, bot_last;
	logic [ROW_W-1:0] up_row, ptr_inc;
	logic [OUT_W-1:0] out_q;

	assign nr    = clamp_size(rows_q, SIZE_W'(ROWS));
	assign nc    = clamp_size(cols_q, SIZE_W'(COLS));
	assign nr_m1 = ROW_W'(nr - SIZE_W'(1));
	assign nc_m1 = COL_W'(nc - SIZE_W'(1));

	assign in_row   = in_data[ROW_LSB +: ROW_W];
	assign in_col   = in_data[COL_LSB +: COL_W];
	assign in_alive = in_data[ALIVE_LSB];

	assign up_row  = (in_row == '0) ? nr_m1 : in_row - ROW_W'(1);
	assign ptr_inc = ({1'b0, ptr_q} + SIZE_W'(1) >= nr) ? '0 : ptr_q + ROW_W'(1);

	assign stat.last_row  = (cur_q == nr_m1);
	assign stat.next_last = ({1'b0, cur_q} + SIZE_W'(1) == {1'b0, nr_m1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default:  rows_q <= rows_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (cmd.wr_row) begin
			vld_q[cur_q] <= 1'b1;
		end else if (cmd.wr_cell && inside_q) begin
			vld_q[row_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_row) begin
			mem[cur_q] <= next_row;
		end else if (cmd.wr_cell && inside_q) begin
			if (vld_q[row_q]) begin
				mem[row_q][col_q] <= alive_q;
			end else begin
				mem[row_q] <= COLS'(alive_q) << col_q;
			end
		end
		if (cmd.rd) begin
			rdat_s1 <= mem[ptr_q];
			rvld_s1 <= vld_q[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			row_q    <= in_row;
			col_q    <= in_col;
			alive_q  <= in_alive;
			inside_q <= ({1'b0, in_row} < nr) && ({1'b0, in_col} < nc);
		end
		if (cmd.init_read) begin
			ptr_q <= up_row;
		end else if (cmd.init_step) begin
			ptr_q <= nr_m1;
		end else if (cmd.rd) begin
			ptr_q <= ptr_inc;
		end
		if (cmd.init_step) begin
			cur_q <= '0;
		end else if (cmd.wr_row) begin
			cur_q <= cur_q + ROW_W'(1);
		end
		if (cmd.wr_row && cur_q == '0) begin
			row0_q <= mid_q;
		end
		if (cmd.shift) begin
			top_q <= mid_q;
			mid_q <= bot_q;
			bot_q <= cmd.use_row0 ? row0_q : (rvld_s1 ? rdat_s1 : '0);
		end
		if (cmd.out_load) begin
			out_q <= inside_q ? OUT_W'({cnt[col_q], mid_q[col_q]}) : '0;
		end
	end

	assign top_last = top_q[nc_m1];
	assign mid_last = mid_q[nc_m1];
	assign bot_last = bot_q[nc_m1];

	for (genvar c = 0; c < COLS; c++) begin : g_col
		localparam int CL = (c == 0) ? COLS - 1 : c - 1;
		localparam int CR = (c == COLS - 1) ? 0 : c + 1;
		logic tl, tr, ml, mr, bl, br, at_end, in_use;

		assign at_end = (COL_W'(c) == nc_m1);
		assign in_use = ({1'b0, COL_W'(c)} < nc);
		assign tl = (c == 0) ? top_last : top_q[CL];
		assign ml = (c == 0) ? mid_last : mid_q[CL];
		assign bl = (c == 0) ? bot_last : bot_q[CL];
		assign tr = at_end ? top_q[0] : top_q[CR];
		assign mr = at_end ? mid_q[0] : mid_q[CR];
		assign br = at_end ? bot_q[0] : bot_q[CR];

		assign cnt[c] = CNT_W'(tl) + CNT_W'(top_q[c]) + CNT_W'(tr)
			+ CNT_W'(ml) + CNT_W'(mr)
			+ CNT_W'(bl) + CNT_W'(bot_q[c]) + CNT_W'(br);

		assign next_row[c] = !in_use ? mid_q[c] :
			mid_q[c] ? (cnt[c] == CNT_W'(SURVIVE_LOW) || cnt[c] == CNT_W'(BIRTH_COUNT)) :
			(cnt[c] == CNT_W'(BIRTH_COUNT));
	end

	assign out_data = out_q;

endmodule

// ----- design/toroidal_life_automaton.sv -----
// Cell write: the cell is written in S_WCELL after acceptance, before the next word is taken.
// Cell read: the three neighboring rows are fetched through the single grid memory port,
// one read and one shift per row, before the result word is loaded and the next word is
// taken; a result word still waiting at the output holds a further read back.
// Generation step: per grid row, a shift brings in the next row (read from memory, or a saved
// copy of row 0 for the last row) and the row is written back; all columns update in parallel.
// Reset is asynchronous and active low; the grid reads as all dead and sizes return to 160 x 240.
module toroidal_life_automaton import tla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // op[1:0], row[9:2], col[17:10], alive_in[18]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata   // alive_out[0], neighbour_count[4:1]
);

	cmd_t  cmd;
	stat_t stat;

	tla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tdata[OP_LSB +: OP_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tla_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

// ----- design/tla_checker.sv -----
module tla_checker import tla_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [OP_W-1:0] op;

	assign op = s_tdata[OP_LSB +: OP_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	a_busy_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (op == OP_WRITE || op == OP_STEP) |=> !s_tready)
		else $error("grid update did not hold off the next word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_CNT_LSB +: CNT_W] <= CNT_W'(8))
			&& (m_tdata[OUT_W-1:OUT_CNT_LSB+CNT_W] == '0))
		else $error("neighbor count out of range");

endmodule

bind toroidal_life_automaton tla_checker u_tla_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
	import tla_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic             alive;
		logic [CNT_W-1:0] count;
	} cell_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;

	bit                life_grid [0:ROWS-1][0:COLS-1];
	bit                next_gen [0:ROWS-1][0:COLS-1];
	logic [SIZE_W-1:0] rows_cfg;
	logic [SIZE_W-1:0] cols_cfg;
	cell_report_t      expected_reads [$];

	bit no_gaps;
	int fail_count;
	int cycle_count;
	int n_writes, n_steps, n_reads, n_reads_outside, n_unused, n_sizes, n_checked;

	toroidal_life_automaton u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic int grid_span(input logic [SIZE_W-1:0] v, input int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int live_neighbours(input int r, input int c, input int nr, input int nc);
		int up, dn, lf, rt, n;
		up = (r == 0) ? nr - 1 : r - 1;
		dn = (r + 1 >= nr) ? 0 : r + 1;
		lf = (c == 0) ? nc - 1 : c - 1;
		rt = (c + 1 >= nc) ? 0 : c + 1;
		n = life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt]
			+ life_grid[r][lf] + life_grid[r][rt]
			+ life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
		return n;
	endfunction

	function automatic void advance_generation(input int nr, input int nc);
		int n;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++) begin
				n = live_neighbours(r, c, nr, nc);
				if (life_grid[r][c])
					next_gen[r][c] = (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
				else
					next_gen[r][c] = (n == BIRTH_COUNT);
			end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				life_grid[r][c] = next_gen[r][c];
	endfunction

	// Updates the grid copy for one accepted word and queues the reply of a read.
	function automatic void predict_word(input logic [OP_W-1:0] op, input logic [7:0] row,
			input logic [7:0] col, input logic alive);
		int nr, nc;
		bit on_grid;
		cell_report_t rep;
		nr = grid_span(rows_cfg, ROWS);
		nc = grid_span(cols_cfg, COLS);
		on_grid = (row < nr) && (col < nc);
		case (op)
			OP_WRITE: begin
				n_writes++;
				if (on_grid)
					life_grid[row][col] = alive;
			end
			OP_STEP: begin
				n_steps++;
				advance_generation(nr, nc);
			end
			OP_READ: begin
				n_reads++;
				if (!on_grid)
					n_reads_outside++;
				rep.alive = on_grid ? life_grid[row][col] : 1'b0;
				rep.count = on_grid ? CNT_W'(live_neighbours(row, col, nr, nc)) : '0;
				expected_reads.push_back(rep);
			end
			default: begin
				n_unused++;
			end
		endcase
	endfunction

	task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] row,
			input logic [7:0] col, input logic alive);
		int gap;
		logic [IN_W-1:0] word;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		word = '0;
		word[OP_LSB +: OP_W] = op;
		word[ROW_LSB +: 8] = row;
		word[COL_LSB +: 8] = col;
		word[ALIVE_LSB] = alive;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_word(op, row, col, alive);
	endtask

	task automatic wait_idle(input int extra_cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_reads.size() != 0)
			@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic settle();
		wait_idle(3 * grid_span(rows_cfg, ROWS) + 16);
	endtask

	task automatic write_size(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS)
			rows_cfg = val;
		else
			cols_cfg = val;
		n_sizes++;
	endtask

	function automatic logic [7:0] pick_coord(input int n);
		int span;
		span = (n < 10) ? n : 10;
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, span - 1));
		return 8'($urandom_range(0, n - 1));
	endfunction

	// Result side: stalls at random, then compares each word with the oldest expected read.
	initial begin : result_sink
		int stall;
		cell_report_t want;
		m_tready = 1'b0;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (expected_reads.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = expected_reads.pop_front();
				n_checked++;
				if (m_tdata[OUT_ALIVE_LSB] !== want.alive) begin
					$display("%0t: alive_out expected %0d, got %0d", $time, want.alive,
						m_tdata[OUT_ALIVE_LSB]);
					fail_count++;
				end
				if (m_tdata[OUT_CNT_LSB +: CNT_W] !== want.count) begin
					$display("%0t: neighbour_count expected %0d, got %0d", $time, want.count,
						m_tdata[OUT_CNT_LSB +: CNT_W]);
					fail_count++;
				end
			end
		end
	end

	// Reset sizes: wrap across the far corner, and cells beyond the size in use.
	task automatic test_reset_geometry();
		send_word(OP_WRITE, 8'd159, 8'd239, 1'b1);
		send_word(OP_WRITE, 8'd0, 8'd0, 1'b1);
		send_word(OP_READ, 8'd0, 8'd239, 1'b0);
		send_word(OP_WRITE, 8'd200, 8'd5, 1'b1);
		send_word(OP_READ, 8'd200, 8'd5, 1'b0);
		send_word(OP_READ, 8'd5, 8'd250, 1'b0);
		send_word(OP_STEP, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'd0, 8'd0, 1'b0);
		settle();
	endtask

	// Sizes below the minimum clamp to 3 x 3, where every other cell is a neighbor.
	task automatic test_clamped_full_torus();
		write_size(REG_ROWS, 9'd0);
		write_size(REG_COLS, 9'd2);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				if (r != 1 || c != 1)
					send_word(OP_WRITE, 8'(r), 8'(c), 1'b1);
		send_word(OP_READ, 8'd1, 8'd1, 1'b0);
		send_word(OP_UNUSED, 8'd2, 8'd2, 1'b0);
		send_word(OP_STEP, 8'hff, 8'hff, 1'b1);
		send_word(OP_READ, 8'd2, 8'd2, 1'b0);
		settle();
	endtask

	// Sizes above the maximum clamp to the full grid; a birth across both wrap edges.
	task automatic test_largest_grid();
		write_size(REG_ROWS, 9'd511);
		write_size(REG_COLS, 9'd257);
		send_word(OP_WRITE, 8'd255, 8'd255, 1'b1);
		send_word(OP_WRITE, 8'd0, 8'd0, 1'b1);
		send_word(OP_WRITE, 8'd255, 8'd0, 1'b1);
		send_word(OP_READ, 8'd0, 8'd255, 1'b1);
		send_word(OP_STEP, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'd0, 8'd255, 1'b0);
		settle();
	endtask

	task automatic test_random_phases();
		int nr, nc, pick;
		logic [SIZE_W-1:0] rv, cv;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin
					rv = 9'd3;
					cv = 9'd3;
				end
				1: begin
					rv = 9'd256;
					cv = 9'd5;
				end
				2: begin
					rv = 9'd4;
					cv = 9'd256;
				end
				3: begin
					rv = SIZE_W'($urandom_range(0, 511));
					cv = SIZE_W'($urandom_range(0, 511));
				end
				default: begin
					rv = SIZE_W'($urandom_range(0, 20));
					cv = SIZE_W'($urandom_range(0, 20));
				end
			endcase
			settle();
			no_gaps = (phase % 4 == 1);
			write_size(REG_ROWS, rv);
			write_size(REG_COLS, cv);
			nr = grid_span(rows_cfg, ROWS);
			nc = grid_span(cols_cfg, COLS);
			for (int i = 0; i < 50; i++) begin
				pick = $urandom_range(0, 99);
				if (i < 10 || pick < 30)
					send_word(OP_WRITE, pick_coord(nr), pick_coord(nc), 1'($urandom_range(0, 1)));
				else if (pick < 70)
					send_word(OP_READ, pick_coord(nr), pick_coord(nc), 1'($urandom_range(0, 1)));
				else if (pick < 82 && (nr * nc <= 2048 || $urandom_range(0, 9) == 0))
					send_word(OP_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else if (pick < 96)
					send_word(OP_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else if (pick < 98)
					wait_idle(0);
				else
					send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		no_gaps = 1'b0;
		rows_cfg = ROWS_RESET;
		cols_cfg = COLS_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_geometry();
		test_clamped_full_torus();
		test_largest_grid();
		test_random_phases();
		settle();

		$display("Covered %0d cell writes, %0d generation steps and %0d unused-op words.",
			n_writes, n_steps, n_unused);
		$display("Checked %0d of %0d reads (%0d off the grid) across %0d size writes.",
			n_checked, n_reads, n_reads_outside, n_sizes);
		if (fail_count == 0 && expected_reads.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tla_pkg.sv
design/tla_ctrl.sv
design/tla_datapath.sv
design/toroidal_life_automaton.sv
design/tla_checker.sv
tb/testbench.sv
